/* hdl/color_threshold_blob_stats_unit_macros.svh */
// assertion macros shared by the colour blob statistics modules
`ifndef COLOR_THRESHOLD_BLOB_STATS_UNIT_MACROS_SVH
`define COLOR_THRESHOLD_BLOB_STATS_UNIT_MACROS_SVH

// condition and consequence in the same cycle
`define CTBS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ctbs assertion failed");

// consequence in the cycle after the condition
`define CTBS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ctbs assertion failed");

`endif

/* hdl/ctbs_pkg.sv */
// types and constants shared by the colour blob statistics modules
package ctbs_pkg;

    localparam int SAMPLE_W      = 8;
    localparam int CNT_W         = 21;
    localparam int PROD_W        = 31;
    localparam int COORD_FIELD_W = 10;
    localparam int DENS_W        = 16;
    localparam int S_TDATA_W     = 48;
    localparam int M_TDATA_W     = 104;
    localparam int PADDR_W       = 5;
    localparam int PDATA_W       = 32;

    localparam logic [CNT_W-1:0]  COUNT_MAX     = {CNT_W{1'b1}};
    localparam logic [9:0]        DENSITY_SCALE = 10'd1000;
    localparam logic [DENS_W-1:0] DENSITY_MAX   = {DENS_W{1'b1}};

    // channel select codes
    localparam logic [1:0] CH_SEL_C0  = 2'd0;
    localparam logic [1:0] CH_SEL_C1  = 2'd1;
    localparam logic [1:0] CH_SEL_C2  = 2'd2;
    localparam logic [1:0] CH_SEL_ALL = 2'd3;

    typedef enum logic [2:0] {
        REG_LOW_C0,
        REG_HIGH_C0,
        REG_LOW_C1,
        REG_HIGH_C1,
        REG_LOW_C2,
        REG_HIGH_C2,
        REG_CHAN_SEL,
        REG_INVERT
    } reg_idx_t;

    typedef struct packed {
        logic [2:0][SAMPLE_W-1:0] low_bound;
        logic [2:0][SAMPLE_W-1:0] high_bound;
        logic [1:0]               chan_sel;
        logic                     invert;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC,
        ST_MUL,
        ST_DENS,
        ST_DENS_WAIT,
        ST_CCOL,
        ST_CCOL_WAIT,
        ST_CROW,
        ST_CROW_WAIT,
        ST_HOLD
    } state_t;

endpackage

/* hdl/ctbs_regs.sv */
// configuration register file behind the apb port
module ctbs_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ctbs_pkg::PADDR_W-1:0]  paddr,
    input  logic [ctbs_pkg::PDATA_W-1:0]  pwdata,
    output logic [ctbs_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output ctbs_pkg::cfg_t                cfg
);

    ctbs_pkg::cfg_t     cfg_reg;
    ctbs_pkg::cfg_t     cfg_next;
    ctbs_pkg::reg_idx_t idx;
    logic               wr_en;

    assign idx    = ctbs_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                ctbs_pkg::REG_LOW_C0:   cfg_next.low_bound[0]  = pwdata[7:0];
                ctbs_pkg::REG_HIGH_C0:  cfg_next.high_bound[0] = pwdata[7:0];
                ctbs_pkg::REG_LOW_C1:   cfg_next.low_bound[1]  = pwdata[7:0];
                ctbs_pkg::REG_HIGH_C1:  cfg_next.high_bound[1] = pwdata[7:0];
                ctbs_pkg::REG_LOW_C2:   cfg_next.low_bound[2]  = pwdata[7:0];
                ctbs_pkg::REG_HIGH_C2:  cfg_next.high_bound[2] = pwdata[7:0];
                ctbs_pkg::REG_CHAN_SEL: cfg_next.chan_sel      = pwdata[1:0];
                ctbs_pkg::REG_INVERT:   cfg_next.invert        = pwdata[0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.low_bound  <= '0;
            cfg_reg.high_bound <= '1;
            cfg_reg.chan_sel   <= ctbs_pkg::CH_SEL_ALL;
            cfg_reg.invert     <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (idx)
            ctbs_pkg::REG_LOW_C0:   prdata = ctbs_pkg::PDATA_W'(cfg_reg.low_bound[0]);
            ctbs_pkg::REG_HIGH_C0:  prdata = ctbs_pkg::PDATA_W'(cfg_reg.high_bound[0]);
            ctbs_pkg::REG_LOW_C1:   prdata = ctbs_pkg::PDATA_W'(cfg_reg.low_bound[1]);
            ctbs_pkg::REG_HIGH_C1:  prdata = ctbs_pkg::PDATA_W'(cfg_reg.high_bound[1]);
            ctbs_pkg::REG_LOW_C2:   prdata = ctbs_pkg::PDATA_W'(cfg_reg.low_bound[2]);
            ctbs_pkg::REG_HIGH_C2:  prdata = ctbs_pkg::PDATA_W'(cfg_reg.high_bound[2]);
            ctbs_pkg::REG_CHAN_SEL: prdata = ctbs_pkg::PDATA_W'(cfg_reg.chan_sel);
            ctbs_pkg::REG_INVERT:   prdata = ctbs_pkg::PDATA_W'(cfg_reg.invert);
            default:                prdata = '0;
        endcase
    end

endmodule

/* hdl/ctbs_match.sv */
// per-pixel colour window test and bound sanity check
module ctbs_match (
    input  ctbs_pkg::cfg_t                 cfg,
    input  logic [ctbs_pkg::SAMPLE_W-1:0]  sample_a,
    input  logic [ctbs_pkg::SAMPLE_W-1:0]  sample_b,
    input  logic [ctbs_pkg::SAMPLE_W-1:0]  sample_c,
    output logic                           pix_hit,
    output logic                           bounds_ok
);

    logic [2:0]                    in_win;
    logic [ctbs_pkg::SAMPLE_W-1:0] sel_lo;
    logic [ctbs_pkg::SAMPLE_W-1:0] sel_hi;
    logic                          single_hit;
    logic                          raw_hit;

    assign in_win[0] = (sample_a >= cfg.low_bound[0]) && (sample_a <= cfg.high_bound[0]);
    assign in_win[1] = (sample_b >= cfg.low_bound[1]) && (sample_b <= cfg.high_bound[1]);
    assign in_win[2] = (sample_c >= cfg.low_bound[2]) && (sample_c <= cfg.high_bound[2]);

    // single-channel mode tests sample_a against the chosen channel's window
    always_comb begin
        case (cfg.chan_sel)
            ctbs_pkg::CH_SEL_C0: begin
                sel_lo = cfg.low_bound[0];
                sel_hi = cfg.high_bound[0];
            end
            ctbs_pkg::CH_SEL_C1: begin
                sel_lo = cfg.low_bound[1];
                sel_hi = cfg.high_bound[1];
            end
            ctbs_pkg::CH_SEL_C2: begin
                sel_lo = cfg.low_bound[2];
                sel_hi = cfg.high_bound[2];
            end
            default: begin
                sel_lo = cfg.low_bound[0];
                sel_hi = cfg.high_bound[0];
            end
        endcase
    end

    assign single_hit = (sample_a >= sel_lo) && (sample_a <= sel_hi);
    assign raw_hit    = (cfg.chan_sel == ctbs_pkg::CH_SEL_ALL) ? (&in_win) : single_hit;
    assign pix_hit    = raw_hit ^ cfg.invert;

    assign bounds_ok = (cfg.low_bound[0] <= cfg.high_bound[0]) &&
                       (cfg.low_bound[1] <= cfg.high_bound[1]) &&
                       (cfg.low_bound[2] <= cfg.high_bound[2]);

endmodule

/* hdl/ctbs_div.sv */
// shared restoring divider, one quotient bit per cycle
`include "color_threshold_blob_stats_unit_macros.svh"

module ctbs_div #(
    parameter int DW = 31,
    parameter int VW = 21
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [DW-1:0]       dividend,
    input  logic [VW-1:0]       divisor,
    output logic [DW-1:0]       quotient,
    output ctbs_pkg::div_stat_t stat
);

    localparam int CNT_W = $clog2(DW + 1);

    logic [VW-1:0]    rem_reg;
    logic [VW-1:0]    rem_next;
    logic [DW-1:0]    quo_reg;
    logic [DW-1:0]    quo_next;
    logic [VW-1:0]    dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [VW:0]      trial;
    logic [VW:0]      diff;
    logic             fits;
    logic             last_step;

    assign trial     = {rem_reg, quo_reg[DW-1]};
    assign diff      = trial - {1'b0, dsr_reg};
    assign fits      = trial >= {1'b0, dsr_reg};
    assign last_step = busy_reg && (cnt_reg == CNT_W'(1));

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CNT_W'(DW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so it fits in VW bits
            rem_next  = fits ? diff[VW-1:0] : trial[VW-1:0];
            quo_next  = {quo_reg[DW-2:0], fits};
            cnt_next  = cnt_reg - CNT_W'(1);
            busy_next = !last_step;
            done_next = last_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start) begin
            dsr_reg <= divisor;
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    `CTBS_ASSERT_NEXT(a_div_start_busy, aclk, aresetn, start, busy_reg)
    `CTBS_ASSERT_NEXT(a_div_finish, aclk, aresetn, last_step && !start, done_reg && !busy_reg)
    `CTBS_ASSERT_SAME(a_div_done_idle, aclk, aresetn, done_reg, !busy_reg)

endmodule

/* hdl/color_threshold_blob_stats_unit.sv */
// colour threshold blob statistics: top level with accumulators and sequencer
//
//  channel   | direction | beat contents
//  ----------+-----------+---------------------------------------------------
//  s_ axis   | in        | one pixel: three samples, column, row; tlast ends frame
//  m_ axis   | out       | one frame result: count, box, centroid, density
//  apb       | in/out    | window bounds, channel select, invert
//
// each pixel goes through capture, then window test and accumulator update.
// after the frame's last pixel, the shared one-bit-per-cycle divider forms density,
// centre column and centre row in turn; a flat box skips the density division, and
// an empty frame or bad bounds skip all three.
// s_tready is low during that sequence and while a finished result waits for
// an earlier one still held in the output register.
// reset is synchronous, active low, and clears control state and accumulators.
`include "color_threshold_blob_stats_unit_macros.svh"

module color_threshold_blob_stats_unit #(
    parameter int COORD_BITS = 10
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // sample_a, sample_b, sample_c, col, row_pos from bit 0 up, zero padded
    input  logic [ctbs_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // match_count, box_left, box_top, box_right, box_bottom, center_col,
    // center_row, fill_density from bit 0 up, zero padded
    output logic [ctbs_pkg::M_TDATA_W-1:0]  m_tdata,
    // bounds_ok
    output logic                            m_tuser,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ctbs_pkg::PADDR_W-1:0]    paddr,
    input  logic [ctbs_pkg::PDATA_W-1:0]    pwdata,
    output logic [ctbs_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);

    localparam int CW     = COORD_BITS;
    localparam int CNT_W  = ctbs_pkg::CNT_W;
    localparam int SUM_W  = CNT_W + CW;
    localparam int SPAN_W = 2 * CW;
    localparam int PROD_W = ctbs_pkg::PROD_W;
    localparam int DIV_DW = (SUM_W > PROD_W) ? SUM_W : PROD_W;
    localparam int DIV_VW = (SPAN_W > CNT_W) ? SPAN_W : CNT_W;
    localparam int FW     = ctbs_pkg::COORD_FIELD_W;
    localparam int EXT_W  = (CW > FW) ? CW : FW;

    ctbs_pkg::state_t    state_reg;
    ctbs_pkg::state_t    state_next;
    ctbs_pkg::cfg_t      cfg;
    ctbs_pkg::div_stat_t div_stat;

    // captured pixel
    logic [7:0]    pix_a_reg;
    logic [7:0]    pix_b_reg;
    logic [7:0]    pix_c_reg;
    logic [CW-1:0] x_reg;
    logic [CW-1:0] y_reg;
    logic          last_reg;
    logic [EXT_W-1:0] col_ext;
    logic [EXT_W-1:0] row_ext;

    // accumulators
    logic [CNT_W-1:0] hit_total_reg;
    logic [CW-1:0]    min_col_reg;
    logic [CW-1:0]    min_row_reg;
    logic [CW-1:0]    max_col_reg;
    logic [CW-1:0]    max_row_reg;
    logic [SUM_W-1:0] col_sum_reg;
    logic [SUM_W-1:0] row_sum_reg;

    // frame-end working registers
    logic              bok_reg;
    logic [SPAN_W-1:0] span_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [ctbs_pkg::DENS_W-1:0] dens_res_reg;
    logic [CW-1:0]     ccol_res_reg;
    logic [CW-1:0]     crow_res_reg;

    logic m_tvalid_reg;
    logic m_tuser_reg;
    logic [ctbs_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [ctbs_pkg::M_TDATA_W-1:0] m_tdata_next;

    logic               pix_hit;
    logic               bounds_ok;
    logic               acc_upd;
    logic               out_load;
    logic               div_start;
    logic [DIV_DW-1:0]  div_dividend;
    logic [DIV_VW-1:0]  div_divisor;
    logic [DIV_DW-1:0]  div_quo;
    logic [ctbs_pkg::DENS_W-1:0] dens_sat;
    logic               any_hit;

    ctbs_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ctbs_match u_match (
        .cfg       (cfg),
        .sample_a  (pix_a_reg),
        .sample_b  (pix_b_reg),
        .sample_c  (pix_c_reg),
        .pix_hit   (pix_hit),
        .bounds_ok (bounds_ok)
    );

    ctbs_div #(
        .DW (DIV_DW),
        .VW (DIV_VW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    // ---------------- sequencer ----------------

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ctbs_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ctbs_pkg::ST_ACC;
                end
            end
            ctbs_pkg::ST_ACC: begin
                state_next = last_reg ? ctbs_pkg::ST_MUL : ctbs_pkg::ST_IDLE;
            end
            ctbs_pkg::ST_MUL: begin
                if (!bounds_ok || (hit_total_reg == '0)) begin
                    state_next = ctbs_pkg::ST_HOLD;
                end else begin
                    state_next = ctbs_pkg::ST_DENS;
                end
            end
            ctbs_pkg::ST_DENS: begin
                // a flat box leaves density at zero
                state_next = (span_reg == '0) ? ctbs_pkg::ST_CCOL : ctbs_pkg::ST_DENS_WAIT;
            end
            ctbs_pkg::ST_DENS_WAIT: begin
                if (div_stat.done) begin
                    state_next = ctbs_pkg::ST_CCOL;
                end
            end
            ctbs_pkg::ST_CCOL: begin
                state_next = ctbs_pkg::ST_CCOL_WAIT;
            end
            ctbs_pkg::ST_CCOL_WAIT: begin
                if (div_stat.done) begin
                    state_next = ctbs_pkg::ST_CROW;
                end
            end
            ctbs_pkg::ST_CROW: begin
                state_next = ctbs_pkg::ST_CROW_WAIT;
            end
            ctbs_pkg::ST_CROW_WAIT: begin
                if (div_stat.done) begin
                    state_next = ctbs_pkg::ST_HOLD;
                end
            end
            ctbs_pkg::ST_HOLD: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ctbs_pkg::ST_IDLE;
                end
            end
            default: state_next = ctbs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        out_load     = 1'b0;
        case (state_reg)
            ctbs_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            ctbs_pkg::ST_DENS: begin
                div_start    = (span_reg != '0);
                div_dividend = DIV_DW'(prod_reg);
                div_divisor  = DIV_VW'(span_reg);
            end
            ctbs_pkg::ST_CCOL: begin
                div_start    = 1'b1;
                div_dividend = DIV_DW'(col_sum_reg);
                div_divisor  = DIV_VW'(hit_total_reg);
            end
            ctbs_pkg::ST_CROW: begin
                div_start    = 1'b1;
                div_dividend = DIV_DW'(row_sum_reg);
                div_divisor  = DIV_VW'(hit_total_reg);
            end
            ctbs_pkg::ST_HOLD: begin
                out_load = !m_tvalid_reg || m_tready;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ctbs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------- pixel capture and accumulation ----------------

    assign col_ext = EXT_W'(s_tdata[33:24]);
    assign row_ext = EXT_W'(s_tdata[43:34]);

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            pix_a_reg <= s_tdata[7:0];
            pix_b_reg <= s_tdata[15:8];
            pix_c_reg <= s_tdata[23:16];
            x_reg     <= col_ext[CW-1:0];
            y_reg     <= row_ext[CW-1:0];
            last_reg  <= s_tlast;
        end
    end

    // the count saturates: matches past the maximum leave everything alone
    assign acc_upd = (state_reg == ctbs_pkg::ST_ACC) && pix_hit &&
                     (hit_total_reg != ctbs_pkg::COUNT_MAX);

    always_ff @(posedge aclk) begin
        if (!aresetn || out_load) begin
            hit_total_reg <= '0;
            min_col_reg   <= '1;
            min_row_reg   <= '1;
            max_col_reg   <= '0;
            max_row_reg   <= '0;
            col_sum_reg   <= '0;
            row_sum_reg   <= '0;
        end else if (acc_upd) begin
            hit_total_reg <= hit_total_reg + CNT_W'(1);
            if (x_reg < min_col_reg) min_col_reg <= x_reg;
            if (y_reg < min_row_reg) min_row_reg <= y_reg;
            if (x_reg > max_col_reg) max_col_reg <= x_reg;
            if (y_reg > max_row_reg) max_row_reg <= y_reg;
            col_sum_reg <= col_sum_reg + SUM_W'(x_reg);
            row_sum_reg <= row_sum_reg + SUM_W'(y_reg);
        end
    end

    // ---------------- frame-end arithmetic ----------------

    assign dens_sat = (div_quo > DIV_DW'(ctbs_pkg::DENSITY_MAX)) ?
                      ctbs_pkg::DENSITY_MAX : div_quo[ctbs_pkg::DENS_W-1:0];

    always_ff @(posedge aclk) begin
        if (state_reg == ctbs_pkg::ST_MUL) begin
            bok_reg      <= bounds_ok;
            span_reg     <= SPAN_W'(max_col_reg - min_col_reg) *
                            SPAN_W'(max_row_reg - min_row_reg);
            prod_reg     <= PROD_W'(hit_total_reg) * PROD_W'(ctbs_pkg::DENSITY_SCALE);
            dens_res_reg <= '0;
            ccol_res_reg <= '0;
            crow_res_reg <= '0;
        end
        if ((state_reg == ctbs_pkg::ST_DENS_WAIT) && div_stat.done) begin
            dens_res_reg <= dens_sat;
        end
        if ((state_reg == ctbs_pkg::ST_CCOL_WAIT) && div_stat.done) begin
            ccol_res_reg <= div_quo[CW-1:0];
        end
        if ((state_reg == ctbs_pkg::ST_CROW_WAIT) && div_stat.done) begin
            crow_res_reg <= div_quo[CW-1:0];
        end
    end

    // ---------------- result register ----------------

    assign any_hit = bok_reg && (hit_total_reg != '0);

    always_comb begin
        logic [EXT_W-1:0] l_ext;
        logic [EXT_W-1:0] t_ext;
        logic [EXT_W-1:0] r_ext;
        logic [EXT_W-1:0] b_ext;
        logic [EXT_W-1:0] cc_ext;
        logic [EXT_W-1:0] cr_ext;
        l_ext  = EXT_W'(min_col_reg);
        t_ext  = EXT_W'(min_row_reg);
        r_ext  = EXT_W'(max_col_reg);
        b_ext  = EXT_W'(max_row_reg);
        cc_ext = EXT_W'(ccol_res_reg);
        cr_ext = EXT_W'(crow_res_reg);
        m_tdata_next = '0;
        if (bok_reg) begin
            m_tdata_next[20:0] = hit_total_reg;
        end
        if (any_hit) begin
            m_tdata_next[30:21] = l_ext[FW-1:0];
            m_tdata_next[40:31] = t_ext[FW-1:0];
            m_tdata_next[50:41] = r_ext[FW-1:0];
            m_tdata_next[60:51] = b_ext[FW-1:0];
            m_tdata_next[70:61] = cc_ext[FW-1:0];
            m_tdata_next[80:71] = cr_ext[FW-1:0];
            m_tdata_next[96:81] = dens_res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= bok_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `CTBS_ASSERT_NEXT(a_accept_goes_acc, aclk, aresetn, s_tvalid && s_tready, state_reg == ctbs_pkg::ST_ACC)
    `CTBS_ASSERT_SAME(a_start_when_free, aclk, aresetn, div_start, !div_stat.busy)
    `CTBS_ASSERT_SAME(a_bad_bounds_zero, aclk, aresetn, m_tvalid && !m_tuser, m_tdata == '0)
    `CTBS_ASSERT_SAME(a_no_hit_zero, aclk, aresetn, m_tvalid && (m_tdata[20:0] == '0), m_tdata[96:21] == '0)

endmodule
